// ----- rtl/core/rat_pkg.sv -----
// Shared constants, types and helper functions of the read-article bitmap tracker.
`default_nettype none

package rat_pkg;

  // Store geometry
  localparam int CAPACITY_ARTICLES = 4096;
  localparam int WORD_BITS         = 32;
  localparam int STORE_WORDS       = (CAPACITY_ARTICLES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W           = $clog2(STORE_WORDS);
  localparam int BIT_W             = $clog2(WORD_BITS);
  localparam int IDX_W             = WADDR_W + BIT_W;
  localparam int CNT_W             = $clog2(CAPACITY_ARTICLES + 1);

  // Field widths
  localparam int ART_W     = 32;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 1'b1;

  localparam logic [ART_W-1:0] RESET_WINDOW_LOW  = 32'd0;
  localparam logic [ART_W-1:0] RESET_WINDOW_HIGH = 32'd4095;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_QUERY        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARK_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MARK_UNREAD  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RANGE_READ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RANGE_UNREAD = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT_RUN     = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_READ,
    S_MODIFY,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_MARK,
    OP_SEEK_ONE,
    OP_SEEK_ZERO
  } op_t;

  // Effective window after clamping
  typedef struct packed {
    logic [ART_W-1:0] lo;
    logic [ART_W-1:0] hi;
    logic [CNT_W-1:0] size;
    logic             nonempty;
  } win_t;

  // Bitmap store access
  typedef struct packed {
    logic                 we;
    logic [WADDR_W-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [WADDR_W-1:0]   raddr;
  } mem_req_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic             changed;
    logic [CNT_W-1:0] unread_total;
    logic [ART_W-1:0] run_end;
    logic [ART_W-1:0] run_start;
    logic             run_found;
    logic             is_read;
  } result_t;

  localparam int IN_TDATA_W  = 2 * ART_W;
  localparam int OUT_TDATA_W = (($bits(result_t) + 7) / 8) * 8;

  // Position of the lowest set bit; zero when none is set
  function automatic logic [BIT_W-1:0] low_one_idx(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] iso;
    logic [BIT_W-1:0]     idx;
    iso = w & (~w + 1'b1);
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Number of set bits, summed per nibble
  function automatic logic [BIT_W:0] pop_count(input logic [WORD_BITS-1:0] w);
    logic [BIT_W:0] sum;
    logic [2:0]     nib;
    sum = '0;
    for (int n = 0; n < WORD_BITS / 4; n++) begin
      nib = 3'(w[4*n]) + 3'(w[4*n+1]) + 3'(w[4*n+2]) + 3'(w[4*n+3]);
      sum = sum + (BIT_W+1)'(nib);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rat_win.sv -----
// Window registers and the clamped effective window derived from them.
`default_nettype none

module rat_win
  import rat_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ART_W-1:0]     cfg_data,
  output win_t                      win
);

  logic [ART_W-1:0] window_low_r;
  logic [ART_W-1:0] window_high_r;
  win_t             win_r;
  win_t             win_nxt;

  logic [ART_W:0]   cap_hi;
  logic [ART_W:0]   clamp_hi;
  logic [ART_W-1:0] span;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_low_r  <= RESET_WINDOW_LOW;
      window_high_r <= RESET_WINDOW_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LOW:  window_low_r  <= cfg_data;
        REG_WINDOW_HIGH: window_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the top to capacity and to the article range
  always_comb begin
    cap_hi   = {1'b0, window_low_r} + (ART_W+1)'(CAPACITY_ARTICLES - 1);
    clamp_hi = ({1'b0, window_high_r} > cap_hi) ? cap_hi : {1'b0, window_high_r};
    if (clamp_hi[ART_W]) begin
      clamp_hi = {1'b0, {ART_W{1'b1}}};
    end
    span = clamp_hi[ART_W-1:0] - window_low_r;
    win_nxt.lo = window_low_r;
    if (window_high_r < window_low_r) begin
      win_nxt.hi       = '0;
      win_nxt.size     = '0;
      win_nxt.nonempty = 1'b0;
    end else begin
      win_nxt.hi       = clamp_hi[ART_W-1:0];
      win_nxt.size     = span[CNT_W-1:0] + CNT_W'(1);
      win_nxt.nonempty = 1'b1;
    end
  end

  // Register the window; it settles long before the clearing pass ends
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign win = win_r;

endmodule

`default_nettype wire

// ----- rtl/core/rat_store.sv -----
// Bitmap store: one read bit per tracked article, one word per entry.
`default_nettype none

module rat_store
  import rat_pkg::*;
(
  input  wire logic             clk,
  input  wire mem_req_t         req,
  output logic [WORD_BITS-1:0]  rd_data
);

  logic [WORD_BITS-1:0] mem [STORE_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/rat_ctrl.sv -----
// Sequencer: decode, word-by-word read-modify-write and run search over the store.
`default_nettype none

module rat_ctrl
  import rat_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire win_t                 win,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [KIND_W-1:0]    in_kind,
  input  wire logic [ART_W-1:0]     in_first,
  input  wire logic [ART_W-1:0]     in_last,
  output mem_req_t                  mem_req,
  input  wire logic [WORD_BITS-1:0] rd_data,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output result_t                   res
);

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ART_W-1:0]   first_r, first_nxt;
  logic [ART_W-1:0]   last_r, last_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   end_r, end_nxt;
  logic               val_r, val_nxt;
  logic [CNT_W-1:0]   unread_r, unread_nxt;
  logic               dirty_r, dirty_nxt;
  logic               is_read_r, is_read_nxt;
  logic               found_r, found_nxt;
  logic [ART_W-1:0]   rs_r, rs_nxt;
  logic [ART_W-1:0]   re_r, re_nxt;
  logic [WADDR_W-1:0] clr_r, clr_nxt;

  // Decode terms
  logic             first_ge_lo, first_le_hi;
  logic             inwin, rvalid, svalid;
  logic [ART_W-1:0] off_first, off_last, span_hi;
  logic [IDX_W-1:0] a_off, b_off;

  // Word terms
  logic [WADDR_W-1:0]   cur_word, end_word;
  logic [BIT_W-1:0]     cur_bit, end_bit;
  logic                 at_end, last_word, clr_last;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, mark_mask, new_word, flips, seek_bits;
  logic [BIT_W:0]       nflip;
  logic [CNT_W-1:0]     nflip_ext;
  logic                 seek_hit;
  logic [IDX_W-1:0]     hit_idx, next_base;
  logic [WADDR_W:0]     zend_word;
  logic [IDX_W:0]       zpos;
  logic [ART_W-1:0]     rs_hit, re_val;

  // Range and window checks on the held item
  always_comb begin
    first_ge_lo = first_r >= win.lo;
    first_le_hi = first_r <= win.hi;
    inwin       = win.nonempty && first_ge_lo && first_le_hi;
    rvalid      = win.nonempty && (first_r <= last_r) && (last_r >= win.lo) && first_le_hi;
    svalid      = win.nonempty && first_le_hi;
    off_first   = first_r - win.lo;
    off_last    = last_r - win.lo;
    span_hi     = win.hi - win.lo;
    a_off       = first_ge_lo ? off_first[IDX_W-1:0] : '0;
    b_off       = (last_r > win.hi) ? span_hi[IDX_W-1:0] : off_last[IDX_W-1:0];
  end

  // Masks, bit flips and search hits on the word just read
  always_comb begin
    cur_word  = cur_r[IDX_W-1:BIT_W];
    cur_bit   = cur_r[BIT_W-1:0];
    end_word  = end_r[IDX_W-1:BIT_W];
    end_bit   = end_r[BIT_W-1:0];
    at_end    = cur_word == end_word;
    last_word = cur_word == WADDR_W'(STORE_WORDS - 1);
    clr_last  = clr_r == WADDR_W'(STORE_WORDS - 1);
    lo_mask   = WORD_ONES << cur_bit;
    hi_mask   = at_end ? (WORD_ONES >> (BIT_W'(WORD_BITS - 1) - end_bit)) : WORD_ONES;
    mark_mask = lo_mask & hi_mask;
    new_word  = val_r ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
    flips     = rd_data ^ new_word;
    nflip     = pop_count(flips);
    nflip_ext = CNT_W'(nflip);
    seek_bits = ((op_r == OP_SEEK_ZERO) ? ~rd_data : rd_data) & lo_mask;
    seek_hit  = |seek_bits;
    hit_idx   = {cur_word, low_one_idx(seek_bits)};
    next_base = {cur_word + WADDR_W'(1), {BIT_W{1'b0}}};
    zend_word = (WADDR_W+1)'(cur_word) + (WADDR_W+1)'(1);
    zpos      = seek_hit ? {1'b0, hit_idx} : {zend_word, {BIT_W{1'b0}}};
    rs_hit    = win.lo + ART_W'(hit_idx);
    re_val    = win.lo + ART_W'(zpos) - ART_W'(1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        case (kind_r) inside
          KIND_QUERY, KIND_MARK_READ, KIND_MARK_UNREAD:
            state_nxt = inwin ? S_READ : S_DONE;
          KIND_RANGE_READ, KIND_RANGE_UNREAD:
            state_nxt = rvalid ? S_READ : S_DONE;
          KIND_NEXT_RUN:
            state_nxt = svalid ? S_READ : S_DONE;
          default:
            state_nxt = S_DONE;
        endcase
      end
      S_READ: begin
        state_nxt = S_MODIFY;
      end
      S_MODIFY: begin
        unique case (op_r)
          OP_QUERY:     state_nxt = S_DONE;
          OP_MARK:      state_nxt = at_end ? S_DONE : S_READ;
          OP_SEEK_ONE:  state_nxt = (!seek_hit && last_word) ? S_DONE : S_READ;
          OP_SEEK_ZERO: state_nxt = (seek_hit || last_word) ? S_DONE : S_READ;
          default:      state_nxt = S_DONE;
        endcase
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
    // A window write restarts the clearing pass
    if (cfg_we) state_nxt = S_CLEAR;
  end

  // Outputs: handshakes and store access
  always_comb begin
    in_ready      = state_r == S_IDLE;
    res_valid     = state_r == S_DONE;
    mem_req.re    = state_r == S_READ;
    mem_req.raddr = cur_word;
    if (state_r == S_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = clr_r;
      mem_req.wdata = '0;
    end else begin
      mem_req.we    = (state_r == S_MODIFY) && (op_r == OP_MARK);
      mem_req.waddr = cur_word;
      mem_req.wdata = new_word;
    end
    res.changed      = dirty_r;
    res.unread_total = unread_r;
    res.run_end      = re_r;
    res.run_start    = rs_r;
    res.run_found    = found_r;
    res.is_read      = is_read_r;
  end

  // Datapath updates
  always_comb begin
    op_nxt      = op_r;
    kind_nxt    = kind_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    cur_nxt     = cur_r;
    end_nxt     = end_r;
    val_nxt     = val_r;
    unread_nxt  = unread_r;
    dirty_nxt   = dirty_r;
    is_read_nxt = is_read_r;
    found_nxt   = found_r;
    rs_nxt      = rs_r;
    re_nxt      = re_r;
    clr_nxt     = clr_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + WADDR_W'(1);
        if (clr_last) unread_nxt = win.size;
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          first_nxt = in_first;
          last_nxt  = in_last;
        end
      end
      S_DEC: begin
        is_read_nxt = 1'b0;
        found_nxt   = 1'b0;
        rs_nxt      = '0;
        re_nxt      = '0;
        case (kind_r) inside
          KIND_QUERY: begin
            op_nxt  = OP_QUERY;
            cur_nxt = off_first[IDX_W-1:0];
            if (!inwin) is_read_nxt = 1'b1;
          end
          KIND_MARK_READ, KIND_MARK_UNREAD: begin
            op_nxt  = OP_MARK;
            cur_nxt = off_first[IDX_W-1:0];
            end_nxt = off_first[IDX_W-1:0];
            val_nxt = kind_r == KIND_MARK_READ;
            if (inwin) dirty_nxt = 1'b1;
          end
          KIND_RANGE_READ, KIND_RANGE_UNREAD: begin
            op_nxt  = OP_MARK;
            cur_nxt = a_off;
            end_nxt = b_off;
            val_nxt = kind_r == KIND_RANGE_READ;
            if (rvalid) dirty_nxt = 1'b1;
          end
          KIND_NEXT_RUN: begin
            if (!first_ge_lo) begin
              // Articles below the window count as read
              op_nxt    = OP_SEEK_ZERO;
              found_nxt = svalid;
              rs_nxt    = svalid ? first_r : '0;
              cur_nxt   = '0;
            end else begin
              op_nxt  = OP_SEEK_ONE;
              cur_nxt = off_first[IDX_W-1:0];
            end
          end
          default: ;
        endcase
      end
      S_MODIFY: begin
        case (op_r)
          OP_QUERY: begin
            is_read_nxt = rd_data[cur_bit];
          end
          OP_MARK: begin
            if (val_r) begin
              unread_nxt = (unread_r > nflip_ext) ? unread_r - nflip_ext : '0;
            end else begin
              unread_nxt = unread_r + nflip_ext;
            end
            cur_nxt = next_base;
          end
          OP_SEEK_ONE: begin
            if (seek_hit) begin
              found_nxt = 1'b1;
              rs_nxt    = rs_hit;
              cur_nxt   = hit_idx;
              op_nxt    = OP_SEEK_ZERO;
            end else begin
              cur_nxt = next_base;
            end
          end
          OP_SEEK_ZERO: begin
            if (seek_hit || last_word) begin
              re_nxt = re_val;
            end else begin
              cur_nxt = next_base;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (cfg_we) clr_nxt = '0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      dirty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    kind_r    <= kind_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    cur_r     <= cur_nxt;
    end_r     <= end_nxt;
    val_r     <= val_nxt;
    unread_r  <= unread_nxt;
    is_read_r <= is_read_nxt;
    found_r   <= found_nxt;
    rs_r      <= rs_nxt;
    re_r      <= re_nxt;
  end

  // Store read and write never meet on one entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("store read and write hit the same entry");

  // Modify always follows the read that fetched its word
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODIFY) |-> ($past(state_r) == S_READ))
    else $error("word modified without a preceding read");

  // A window write starts the clearing pass
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == S_CLEAR))
    else $error("window write did not restart the clearing pass");

  // The dirty mark only rises until reset
  a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_r |=> dirty_r)
    else $error("dirty mark dropped");

  // Unread count stays within the window once the store is clean
  a_unread_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (unread_r <= win.size))
    else $error("unread count above window size");

endmodule

`default_nettype wire

// ----- rtl/core/read_article_bitmap_tracker.sv -----
// Top level of the read-article bitmap tracker: sequencer, store, window and result register.
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------------------------
//  in      | in_tvalid/in_tready            | tuser: kind; tdata: first_article, last_article
//  out     | out_tvalid/out_tready          | tdata: is_read, run_found, run_start, run_end,
//          |                                |        unread_total, changed
//  cfg     | cfg_we, cfg_index, cfg_data    | 0 window_low, 1 window_high
//
// A query or single mark passes through decode, read and modify before its result.
// A range or run search reads and modifies each store word it visits (a range writes each
// word back through the single store port pair); a found run re-reads its first word once.
// After reset and after every window write a clearing pass over all 128 store words (one
// store word a cycle) runs; no item is taken during it.
// A result waits in the output register while the next item is already taken.
`default_nettype none

module read_article_bitmap_tracker
  import rat_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // first_article, last_article
  input  wire logic [KIND_W-1:0]      in_tuser,   // kind
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // is_read, run_found, run_start, run_end,
                                                  // unread_total, changed
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ART_W-1:0]       cfg_data
);

  win_t                 win;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rd_data;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;

  logic                 out_valid_r, out_valid_nxt;
  result_t              out_data_r;

  rat_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  rat_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  rat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .win       (win),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_first  (in_tdata[ART_W-1:0]),
    .in_last   (in_tdata[2*ART_W-1:ART_W]),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: free when empty or drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) out_valid_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the read-article bitmap tracker: table-driven corner items, then random window phases.
module testbench;
  import rat_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned RES_W          = $bits(result_t);

  // Kinds the block leaves alone
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  // One row of the corner-case table: an item or a register write
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] sel;
    logic [KIND_W-1:0]    kind;
    logic [ART_W-1:0]     first;
    logic [ART_W-1:0]     last;
    bit                   typed;
    result_t              want;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // first_article, last_article
  logic [KIND_W-1:0]      in_tuser = '0;   // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // is_read, run_found, run_start, run_end,
                                           // unread_total, changed
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ART_W-1:0]       cfg_data = '0;

  // Shadow of the tracker
  bit [CAPACITY_ARTICLES-1:0] read_map;
  logic [ART_W-1:0]           reg_low, reg_high;
  logic [ART_W-1:0]           span_lo, span_hi;
  int unsigned                span_size;
  int unsigned                unread_cnt;
  bit                         dirty_mark;

  result_t     pending_answers [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_used = 1'b0;
  int unsigned squeeze_left = 0;

  read_article_bitmap_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clamp the window to the store and work out its size
  function automatic void recompute_span();
    longint unsigned lo, hi, top;
    lo  = reg_low;
    hi  = reg_high;
    top = lo + CAPACITY_ARTICLES - 1;
    if (hi < lo) begin
      span_lo   = reg_low;
      span_hi   = '0;
      span_size = 0;
    end else begin
      if (hi > top) hi = top;
      span_lo   = ART_W'(lo);
      span_hi   = ART_W'(hi);
      span_size = int'(hi - lo + 1);
    end
  endfunction

  function automatic void clear_map();
    read_map = '0;
    recompute_span();
    unread_cnt = span_size;
  endfunction

  function automatic bit in_span(logic [ART_W-1:0] art);
    return span_size != 0 && art >= span_lo && art <= span_hi;
  endfunction

  // Set or clear one bit; only a real change moves the unread count
  function automatic void put_bit(int unsigned idx, bit val);
    if (idx >= span_size) return;
    if (val && !read_map[idx]) begin
      read_map[idx] = 1'b1;
      if (unread_cnt > 0) unread_cnt--;
    end else if (!val && read_map[idx]) begin
      read_map[idx] = 1'b0;
      unread_cnt++;
    end
  endfunction

  // Apply one item to the shadow and return the answer it should give
  function automatic result_t tracker_answer(logic [KIND_W-1:0] kind, logic [ART_W-1:0] first,
                                             logic [ART_W-1:0] last);
    result_t     ans;
    int unsigned idx, a, b;
    ans = '0;
    case (kind)
      KIND_QUERY: begin
        if (!in_span(first) || read_map[first - span_lo]) ans.is_read = 1'b1;
      end
      KIND_MARK_READ, KIND_MARK_UNREAD: begin
        if (in_span(first)) begin
          dirty_mark = 1'b1;
          put_bit(first - span_lo, kind == KIND_MARK_READ);
        end
      end
      KIND_RANGE_READ, KIND_RANGE_UNREAD: begin
        if (span_size != 0 && first <= last && last >= span_lo && first <= span_hi) begin
          a = (first < span_lo) ? 0 : first - span_lo;
          b = (last > span_hi) ? span_hi - span_lo : last - span_lo;
          dirty_mark = 1'b1;
          for (int unsigned i = a; i <= b; i++) put_bit(i, kind == KIND_RANGE_READ);
        end
      end
      KIND_NEXT_RUN: begin
        if (span_size != 0 && first <= span_hi) begin
          // Articles below the window count as read, so the run opens at the start point
          if (first < span_lo) begin
            ans.run_found = 1'b1;
            ans.run_start = first;
            idx = 0;
          end else begin
            idx = first - span_lo;
            while (idx < span_size && !read_map[idx]) idx++;
            if (idx < span_size) begin
              ans.run_found = 1'b1;
              ans.run_start = span_lo + idx;
            end
          end
          if (ans.run_found) begin
            while (idx < span_size && read_map[idx]) idx++;
            ans.run_end = (idx >= span_size) ? span_hi : span_lo + idx - 1;
          end
        end
      end
      default: ;
    endcase
    ans.unread_total = CNT_W'(unread_cnt);
    ans.changed      = dirty_mark;
    return ans;
  endfunction

  function automatic step_t item_row(logic [KIND_W-1:0] kind, logic [ART_W-1:0] first,
                                     logic [ART_W-1:0] last);
    step_t row;
    row       = '{default: '0};
    row.kind  = kind;
    row.first = first;
    row.last  = last;
    return row;
  endfunction

  function automatic step_t typed_row(logic [KIND_W-1:0] kind, logic [ART_W-1:0] first,
                                      logic [ART_W-1:0] last, bit is_read, bit found,
                                      logic [ART_W-1:0] rs, logic [ART_W-1:0] re,
                                      int unsigned unread, bit changed);
    step_t row;
    row                   = item_row(kind, first, last);
    row.typed             = 1'b1;
    row.want              = '0;
    row.want.is_read      = is_read;
    row.want.run_found    = found;
    row.want.run_start    = rs;
    row.want.run_end      = re;
    row.want.unread_total = CNT_W'(unread);
    row.want.changed      = changed;
    return row;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] sel, logic [ART_W-1:0] value);
    step_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.first  = value;
    return row;
  endfunction

  // Article near the current window, now and then anywhere
  function automatic logic [ART_W-1:0] pick_article();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return $urandom;
      1:       return span_lo - $urandom_range(1, 40);
      2:       return span_hi + $urandom_range(1, 40);
      default: return span_lo + $urandom_range(0, (span_size != 0) ? span_size - 1 : 0);
    endcase
  endfunction

  // Offer one item, hold it until the transfer, then queue its answer
  task automatic send_item(logic [KIND_W-1:0] kind, logic [ART_W-1:0] first,
                           logic [ART_W-1:0] last, bit typed, result_t want);
    result_t guess;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {last, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = tracker_answer(kind, first, last);
    pending_answers.push_back(typed ? want : guess);
  endtask

  // Write a window register once the tracker has drained, then wait out its clearing pass
  task automatic write_register(logic [CFG_IDX_W-1:0] sel, logic [ART_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_WINDOW_LOW) reg_low = value;
    else reg_high = value;
    clear_map();
    repeat (2) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // One window setting followed by random traffic
  task automatic run_phase(logic [ART_W-1:0] lo, logic [ART_W-1:0] hi, int unsigned count);
    int unsigned       done_cnt, roll;
    logic [KIND_W-1:0] kind;
    logic [ART_W-1:0]  first, last;
    write_register(REG_WINDOW_LOW, lo);
    write_register(REG_WINDOW_HIGH, hi);
    done_cnt = 0;
    while (done_cnt < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) kind = KIND_QUERY;
      else if (roll < 30) kind = KIND_MARK_READ;
      else if (roll < 40) kind = KIND_MARK_UNREAD;
      else if (roll < 62) kind = KIND_RANGE_READ;
      else if (roll < 72) kind = KIND_RANGE_UNREAD;
      else if (roll < 96) kind = KIND_NEXT_RUN;
      else kind = roll[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
      first = pick_article();
      last  = $urandom;
      if (kind == KIND_RANGE_READ || kind == KIND_RANGE_UNREAD) begin
        // Mostly short ranges; some long, reversed or arbitrary
        roll = $urandom_range(0, 31);
        if (roll == 0) last = $urandom;
        else if (roll < 3) last = pick_article();
        else if (roll < 7) last = first + $urandom_range(0, 5000);
        else last = first + $urandom_range(0, 40);
      end
      send_item(kind, first, last, 1'b0, '0);
      if (kind <= KIND_NEXT_RUN) done_cnt++;
    end
  endtask

  // Compare a transfer on the result side with the oldest expectation
  task automatic check_answer(result_t got);
    result_t want;
    if (pending_answers.size() == 0) begin
      $error("result transfer with no item outstanding");
      mismatches++;
      return;
    end
    want = pending_answers.pop_front();
    if (got.is_read !== want.is_read) begin
      $error("is_read: expected %0d, got %0d", want.is_read, got.is_read);
      mismatches++;
    end
    if (got.run_found !== want.run_found) begin
      $error("run_found: expected %0d, got %0d", want.run_found, got.run_found);
      mismatches++;
    end
    if (got.run_start !== want.run_start) begin
      $error("run_start: expected %0h, got %0h", want.run_start, got.run_start);
      mismatches++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0h, got %0h", want.run_end, got.run_end);
      mismatches++;
    end
    if (got.unread_total !== want.unread_total) begin
      $error("unread_total: expected %0d, got %0d", want.unread_total, got.unread_total);
      mismatches++;
    end
    if (got.changed !== want.changed) begin
      $error("changed: expected %0d, got %0d", want.changed, got.changed);
      mismatches++;
    end
  endtask

  // Result side: check transfers, throttle tready, hold off once for a long stretch
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_answer(result_t'(out_tdata[RES_W-1:0]));
    if (squeeze_left != 0) begin
      out_tready   <= 1'b0;
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_req && !squeeze_used) begin
      squeeze_used <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Abort a run that hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    step_t            plan [$];
    logic [ART_W-1:0] phase_lo [9];
    logic [ART_W-1:0] phase_hi [9];

    reg_low    = RESET_WINDOW_LOW;
    reg_high   = RESET_WINDOW_HIGH;
    dirty_mark = 1'b0;
    clear_map();
    send_idle_pct = 25;
    recv_idle_pct = 63;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Corner cases under the reset window
    plan.push_back(typed_row(KIND_QUERY, 32'd0, 32'd0, 0, 0, 0, 0, 4096, 0));
    plan.push_back(typed_row(KIND_QUERY, 32'd4096, 32'd0, 1, 0, 0, 0, 4096, 0));
    plan.push_back(typed_row(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 4096, 0));
    plan.push_back(typed_row(KIND_NEXT_RUN, 32'd0, 32'd0, 0, 0, 0, 0, 4096, 0));
    plan.push_back(typed_row(KIND_SPARE_LO, 32'd0, 32'hFFFF_FFFF, 0, 0, 0, 0, 4096, 0));
    plan.push_back(typed_row(KIND_MARK_UNREAD, 32'd5, 32'd0, 0, 0, 0, 0, 4096, 1));
    plan.push_back(item_row(KIND_MARK_READ, 32'd0, 32'd0));
    plan.push_back(item_row(KIND_MARK_READ, 32'd4095, 32'd0));
    plan.push_back(item_row(KIND_RANGE_READ, 32'd100, 32'd200));
    plan.push_back(item_row(KIND_RANGE_READ, 32'd300, 32'd200));
    plan.push_back(item_row(KIND_RANGE_UNREAD, 32'd150, 32'd160));
    plan.push_back(item_row(KIND_NEXT_RUN, 32'd1, 32'd0));
    plan.push_back(item_row(KIND_RANGE_READ, 32'd0, 32'hFFFF_FFFF));
    plan.push_back(item_row(KIND_NEXT_RUN, 32'd0, 32'd0));
    plan.push_back(item_row(KIND_RANGE_UNREAD, 32'd0, 32'hFFFF_FFFF));
    // Narrow window: ranges straddling it, searches from below and above
    plan.push_back(cfg_row(REG_WINDOW_LOW, 32'd1000));
    plan.push_back(cfg_row(REG_WINDOW_HIGH, 32'd1099));
    plan.push_back(typed_row(KIND_NEXT_RUN, 32'd0, 32'd0, 0, 1, 0, 999, 100, 1));
    plan.push_back(item_row(KIND_RANGE_READ, 32'd900, 32'd1010));
    plan.push_back(item_row(KIND_NEXT_RUN, 32'd500, 32'd0));
    plan.push_back(item_row(KIND_RANGE_READ, 32'd1090, 32'hFFFF_FFFF));
    plan.push_back(item_row(KIND_NEXT_RUN, 32'd1101, 32'd0));
    // Empty window
    plan.push_back(cfg_row(REG_WINDOW_HIGH, 32'd999));
    plan.push_back(typed_row(KIND_QUERY, 32'd1000, 32'd0, 1, 0, 0, 0, 0, 1));
    plan.push_back(typed_row(KIND_MARK_READ, 32'd1000, 32'd0, 0, 0, 0, 0, 0, 1));
    plan.push_back(typed_row(KIND_NEXT_RUN, 32'd0, 32'd0, 0, 0, 0, 0, 0, 1));
    // Window at the top of the article space
    plan.push_back(cfg_row(REG_WINDOW_LOW, 32'hFFFF_F000));
    plan.push_back(cfg_row(REG_WINDOW_HIGH, 32'hFFFF_FFFF));
    plan.push_back(item_row(KIND_MARK_READ, 32'hFFFF_FFFF, 32'd0));
    plan.push_back(item_row(KIND_NEXT_RUN, 32'hFFFF_FF00, 32'd0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_register(plan[i].sel, plan[i].first);
      else send_item(plan[i].kind, plan[i].first, plan[i].last, plan[i].typed, plan[i].want);
    end

    // Random phases over a spread of window settings
    phase_lo = '{32'd0, 32'd5000, 32'd7, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd123,
                 32'd0};
    phase_hi = '{32'hFFFF_FFFF, 32'd5063, 32'd6, 32'h8000_007F, 32'd0, 32'hFFFF_FFFF, 32'd0,
                 32'd4723, 32'd4095};
    phase_lo[4] = $urandom;
    phase_hi[4] = phase_lo[4] + $urandom_range(0, 300);

    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 63;
      end else if (p < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 7) squeeze_req <= 1'b1;
      run_phase(phase_lo[p], phase_hi[p], (p == 2) ? 40 : 140);
    end

    // Drain and let the pipeline settle
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rat_pkg.sv
rtl/core/rat_win.sv
rtl/core/rat_store.sv
rtl/core/rat_ctrl.sv
rtl/core/read_article_bitmap_tracker.sv
bench/testbench.sv
